// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SWMC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SWMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWMC_ASSERT(lbl, clk, rstn, prop, msg)
`define SWMC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/sqlwmc_pkg.sv =====
// ----------------------------------------------------------------------------
// sqlwmc_pkg
// Types, codes and defaults of the SQL wire message capture block.
// ----------------------------------------------------------------------------
package sqlwmc_pkg;

	localparam int CONN_SLOTS_DEF   = 256;
	localparam int MAX_MESSAGES_DEF = 64;
	localparam int MAX_CAPTURE_DEF  = 16384;

	localparam logic [31:0] SSL_REQUEST_CODE = 32'd80877103;
	localparam logic [31:0] GSS_REQUEST_CODE = 32'd80877104;
	localparam logic [15:0] PROTO_V3_MAJOR   = 16'd3;

	localparam logic [7:0] TAG_QUERY    = 8'h51;
	localparam logic [7:0] TAG_PARSE    = 8'h50;
	localparam logic [7:0] TAG_BIND     = 8'h42;
	localparam logic [7:0] TAG_EXECUTE  = 8'h45;
	localparam logic [7:0] TAG_CLOSE    = 8'h43;
	localparam logic [7:0] TAG_TERMINATE = 8'h58;

	typedef enum logic [2:0] {
		CLS_NONE  = 3'd0,
		CLS_V3    = 3'd1,
		CLS_SSL   = 3'd2,
		CLS_GSS   = 3'd3,
		CLS_OTHER = 3'd4
	} cls_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_CLASSIFY = 3'd1,
		PH_HEADER   = 3'd2,
		PH_PAYLOAD  = 3'd3,
		PH_SKIP     = 3'd4
	} phase_t;

	function automatic logic tag_wanted(input logic [7:0] t);
		return (t == TAG_QUERY) || (t == TAG_PARSE) || (t == TAG_BIND) ||
			(t == TAG_EXECUTE) || (t == TAG_CLOSE) || (t == TAG_TERMINATE);
	endfunction

	function automatic cls_t classify(input logic [31:0] p);
		cls_t c;
		if (p[31:16] == PROTO_V3_MAJOR) begin
			c = CLS_V3;
		end else if (p == SSL_REQUEST_CODE) begin
			c = CLS_SSL;
		end else if (p == GSS_REQUEST_CODE) begin
			c = CLS_GSS;
		end else begin
			c = CLS_OTHER;
		end
		return c;
	endfunction

endpackage

// ===== sv/sqlwmc_ram.sv =====
// ----------------------------------------------------------------------------
// sqlwmc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sqlwmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/sql_wire_message_capture.sv =====
// ----------------------------------------------------------------------------
// sql_wire_message_capture
// Frames frontend SQL wire messages from a byte stream of send calls and
// emits the payload bytes of query and extended-query messages.
// ----------------------------------------------------------------------------
// The input channel carries one byte of a send call, or a close event, per
// transfer (item_valid / item_stall). Each slot's class lives in a RAM with
// a registered read, issued as the transfer is taken; a write
// from the item ahead is forwarded when it hits the same entry.
// The result channel (result_valid / result_stall) carries one captured
// payload byte per transfer from an output register.
// One item is taken every cycle while item_stall is low. A captured byte
// passes through the parse stage register and the output register before
// it is offered on the result channel. Bytes that capture nothing produce
// no transfer.
// While the output register is full and result_stall is high, one more
// item is held in the parse stage and item_stall rises after it.
// After reset the class RAM is swept to zero, one entry per cycle, over all
// CONN_SLOTS entries; item_stall stays high during the sweep.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sql_wire_message_capture #(
	parameter int CONN_SLOTS   = sqlwmc_pkg::CONN_SLOTS_DEF,
	parameter int MAX_MESSAGES = sqlwmc_pkg::MAX_MESSAGES_DEF,
	parameter int MAX_CAPTURE  = sqlwmc_pkg::MAX_CAPTURE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        func,
	input  logic [7:0]  conn_slot,
	input  logic [7:0]  data_byte,
	input  logic [31:0] call_size,
	input  logic        call_first,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  out_slot,
	output logic [7:0]  msg_tag,
	output logic [7:0]  payload_byte,
	output logic [14:0] payload_len,
	output logic [31:0] req_len,
	output logic        msg_first,
	output logic        msg_last
);

	localparam int SLOT_W = (CONN_SLOTS > 1) ? $clog2(CONN_SLOTS) : 1;
	localparam int MC_W   = $clog2(MAX_MESSAGES + 1);
	localparam int CAP_W  = $clog2(MAX_CAPTURE + 1);
	localparam int CLS_W  = 3;

	logic [SLOT_W-1:0] slot_lut [256];

	for (genvar g = 0; g < 256; g++) begin : g_slot_lut
		assign slot_lut[g] = SLOT_W'(g % CONN_SLOTS);
	end

	logic                  clr_q;
	logic [SLOT_W-1:0]     clr_cnt_q;

	logic                  valid_s1;
	logic                  func_s1;
	logic [7:0]            slot_s1;
	logic [SLOT_W-1:0]     idx_s1;
	logic [7:0]            byte_s1;
	logic [31:0]           size_s1;
	logic                  first_s1;

	logic                  byp_q;
	logic [CLS_W-1:0]      byp_data_q;

	sqlwmc_pkg::phase_t    phase_q;
	logic [31:0]           rem_q;
	logic [2:0]            pos_q;
	logic [2:0]            hc_q;
	logic [31:0]           la_q;
	logic [7:0]            tag_q;
	logic [31:0]           ml_q;
	logic [CAP_W-1:0]      cc_q;
	logic [CAP_W-1:0]      cap_q;
	logic [MC_W-1:0]       mc_q;
	logic                  capon_q;
	logic [7:0]            cslot_q;
	logic [SLOT_W-1:0]     cidx_q;
	logic [31:0]           mreq_q;

	sqlwmc_pkg::phase_t    ph_d;
	logic [31:0]           rem_d;
	logic [2:0]            pos_d;
	logic [2:0]            hc_d;
	logic [31:0]           la_d;
	logic [7:0]            tag_d;
	logic [31:0]           ml_d;
	logic [CAP_W-1:0]      cc_d;
	logic [CAP_W-1:0]      cap_d;
	logic [MC_W-1:0]       mc_d;
	logic                  capon_d;
	logic [7:0]            cslot_d;
	logic [SLOT_W-1:0]     cidx_d;
	logic [31:0]           mreq_d;

	logic                  res_v;
	logic                  proc_we;
	logic [SLOT_W-1:0]     proc_waddr;
	logic [CLS_W-1:0]      proc_wdata;

	logic [CLS_W-1:0]      ram_rdata;
	sqlwmc_pkg::cls_t      cls;
	logic [31:0]           la_shift;
	logic [31:0]           len_body;
	logic [CAP_W-1:0]      cap_new;

	logic                  accept;
	logic                  s1_adv;
	logic                  ram_we;
	logic [SLOT_W-1:0]     ram_waddr;
	logic [CLS_W-1:0]      ram_wdata;
	logic [SLOT_W-1:0]     ram_raddr;

	assign s1_adv     = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = clr_q || (valid_s1 && !s1_adv);
	assign accept     = item_valid && !item_stall;

	assign ram_raddr = slot_lut[conn_slot];
	assign ram_we    = clr_q || (s1_adv && proc_we);
	assign ram_waddr = clr_q ? clr_cnt_q : proc_waddr;
	assign ram_wdata = clr_q ? CLS_W'(sqlwmc_pkg::CLS_NONE) : proc_wdata;

	sqlwmc_ram #(
		.WIDTH(CLS_W),
		.DEPTH(CONN_SLOTS)
	) u_class_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cls      = sqlwmc_pkg::cls_t'(byp_q ? byp_data_q : ram_rdata);
	assign la_shift = {la_q[23:0], byte_s1};
	assign len_body = la_shift - 32'd4;
	assign cap_new  = (len_body > 32'(MAX_CAPTURE)) ? CAP_W'(MAX_CAPTURE) : CAP_W'(len_body);

	always_comb begin
		ph_d       = phase_q;
		rem_d      = rem_q;
		pos_d      = pos_q;
		hc_d       = hc_q;
		la_d       = la_q;
		tag_d      = tag_q;
		ml_d       = ml_q;
		cc_d       = cc_q;
		cap_d      = cap_q;
		mc_d       = mc_q;
		capon_d    = capon_q;
		cslot_d    = cslot_q;
		cidx_d     = cidx_q;
		mreq_d     = mreq_q;
		res_v      = 1'b0;
		proc_we    = 1'b0;
		proc_waddr = idx_s1;
		proc_wdata = CLS_W'(sqlwmc_pkg::CLS_NONE);
		if (valid_s1 && func_s1) begin
			proc_we = 1'b1;
		end else if (valid_s1) begin
			if (first_s1) begin
				cslot_d = slot_s1;
				cidx_d  = idx_s1;
				rem_d   = size_s1;
				pos_d   = 3'd0;
				mc_d    = '0;
				hc_d    = 3'd0;
				capon_d = 1'b0;
				if (cls == sqlwmc_pkg::CLS_NONE) begin
					ph_d = (size_s1 < 32'd8) ? sqlwmc_pkg::PH_SKIP : sqlwmc_pkg::PH_CLASSIFY;
				end else if (cls == sqlwmc_pkg::CLS_V3 || cls == sqlwmc_pkg::CLS_SSL ||
						cls == sqlwmc_pkg::CLS_GSS) begin
					ph_d = sqlwmc_pkg::PH_HEADER;
				end else begin
					ph_d = sqlwmc_pkg::PH_SKIP;
				end
			end
			if (ph_d == sqlwmc_pkg::PH_IDLE || rem_d == 32'd0) begin
				ph_d = sqlwmc_pkg::PH_IDLE;
			end else begin
				case (ph_d)
					sqlwmc_pkg::PH_CLASSIFY: begin
						if (pos_d >= 3'd4) begin
							la_d = la_shift;
							if (pos_d == 3'd7) begin
								proc_we    = 1'b1;
								proc_waddr = cidx_d;
								proc_wdata = CLS_W'(sqlwmc_pkg::classify(la_shift));
								ph_d       = sqlwmc_pkg::PH_SKIP;
							end
						end
					end
					sqlwmc_pkg::PH_HEADER: begin
						if (hc_d == 3'd0) begin
							if (mc_d >= MC_W'(MAX_MESSAGES) || rem_d < 32'd5) begin
								ph_d = sqlwmc_pkg::PH_SKIP;
							end else begin
								tag_d  = byte_s1;
								mreq_d = rem_d;
								la_d   = 32'd0;
								hc_d   = 3'd1;
							end
						end else begin
							la_d = la_shift;
							hc_d = hc_d + 3'd1;
							if (hc_d == 3'd5) begin
								hc_d = 3'd0;
								if (la_shift < 32'd5 || 32'(cap_new) > rem_d - 32'd1) begin
									ph_d = sqlwmc_pkg::PH_SKIP;
								end else begin
									ml_d    = len_body;
									cc_d    = '0;
									cap_d   = cap_new;
									capon_d = sqlwmc_pkg::tag_wanted(tag_d);
									mc_d    = mc_d + MC_W'(1);
									ph_d    = sqlwmc_pkg::PH_PAYLOAD;
								end
							end
						end
					end
					sqlwmc_pkg::PH_PAYLOAD: begin
						if (capon_d && cc_d < cap_d) begin
							res_v = 1'b1;
							cc_d  = cc_d + CAP_W'(1);
						end
						ml_d = ml_d - 32'd1;
						if (ml_d == 32'd0) begin
							ph_d    = sqlwmc_pkg::PH_HEADER;
							hc_d    = 3'd0;
							capon_d = 1'b0;
						end
					end
					default: begin
					end
				endcase
				rem_d = rem_d - 32'd1;
				pos_d = pos_d + 3'd1;
				if (rem_d == 32'd0) begin
					ph_d = sqlwmc_pkg::PH_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
			if (clr_cnt_q == SLOT_W'(CONN_SLOTS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			byp_q      <= 1'b0;
			byp_data_q <= '0;
		end else begin
			if (accept) begin
				valid_s1   <= 1'b1;
				byp_q      <= s1_adv && proc_we && (proc_waddr == ram_raddr);
				byp_data_q <= proc_wdata;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= func;
			slot_s1  <= conn_slot;
			idx_s1   <= ram_raddr;
			byte_s1  <= data_byte;
			size_s1  <= call_size;
			first_s1 <= call_first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sqlwmc_pkg::PH_IDLE;
		end else if (s1_adv) begin
			phase_q <= ph_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			pos_q   <= '0;
			hc_q    <= '0;
			la_q    <= '0;
			tag_q   <= '0;
			ml_q    <= '0;
			cc_q    <= '0;
			cap_q   <= '0;
			mc_q    <= '0;
			capon_q <= 1'b0;
			cslot_q <= '0;
			cidx_q  <= '0;
			mreq_q  <= '0;
		end else if (s1_adv) begin
			rem_q   <= rem_d;
			pos_q   <= pos_d;
			hc_q    <= hc_d;
			la_q    <= la_d;
			tag_q   <= tag_d;
			ml_q    <= ml_d;
			cc_q    <= cc_d;
			cap_q   <= cap_d;
			mc_q    <= mc_d;
			capon_q <= capon_d;
			cslot_q <= cslot_d;
			cidx_q  <= cidx_d;
			mreq_q  <= mreq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (s1_adv) begin
			result_valid <= res_v;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && res_v) begin
			out_slot     <= cslot_d;
			msg_tag      <= tag_d;
			payload_byte <= byte_s1;
			payload_len  <= 15'(cap_q);
			req_len      <= mreq_d;
			msg_first    <= (cc_q == '0);
			msg_last     <= ({1'b0, cc_q} + (CAP_W + 1)'(1)) == {1'b0, cap_q};
		end
	end

	`SWMC_ASSERT(a_sweep_holds_input, clk, arst_n, clr_q |-> item_stall, "Input taken during class sweep")
	`SWMC_ASSERT(a_sweep_no_parse_write, clk, arst_n, clr_q |-> !(s1_adv && proc_we), "Parse write during class sweep")
	`SWMC_ASSERT(a_result_in_payload, clk, arst_n, res_v |-> (phase_q == sqlwmc_pkg::PH_PAYLOAD) && capon_q, "Capture outside a wanted message body")
	`SWMC_ASSERT(a_header_count_range, clk, arst_n, hc_q < 3'd5, "Header byte count out of range")
	`SWMC_ASSERT(a_capture_within_cap, clk, arst_n, cc_q <= cap_q, "Captured count beyond capture length")

endmodule

// ===== sim/tb_sql_wire_message_capture.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sql_wire_message_capture
// Self-checking bench for the frontend wire message capture block. A short
// table of directed bytes is followed by random send calls: startup packets
// of every class, framed message runs and broken framing of several kinds,
// with stray bytes and close events mixed in. A predictor that tracks the
// per-slot classes and the framing state gives the expected captured bytes,
// and each result transfer is checked field by field against them.
// ----------------------------------------------------------------------------
module tb_sql_wire_message_capture;
	import sqlwmc_pkg::*;

	localparam int RAND_ITEMS   = 950;
	localparam int QUIET_ITEMS  = 100;
	localparam int HOLD_CYCLES  = 600;
	localparam int HOLD_AFTER   = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int DIR_ROWS     = 25;

	typedef struct packed {
		logic [7:0]  slot;
		logic [7:0]  tag;
		logic [7:0]  pbyte;
		logic [14:0] plen;
		logic [31:0] rlen;
		logic        first;
		logic        last;
	} capture_t;

	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} chk_t;

	typedef struct packed {
		logic        func;
		logic [7:0]  slot;
		logic [7:0]  data;
		logic [31:0] size;
		logic        first;
		chk_t        chk;
		capture_t    want;
	} wire_item_t;

	typedef enum logic [2:0] {
		BRK_NONE, BRK_LEN, BRK_LONG, BRK_JUNK, BRK_CUT, BRK_OPEN, BRK_HUGE, BRK_CLOSE
	} brk_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic        func;
	logic [7:0]  conn_slot;
	logic [7:0]  data_byte;
	logic [31:0] call_size;
	logic        call_first;
	logic        result_valid;
	logic        result_stall;
	logic [7:0]  out_slot;
	logic [7:0]  msg_tag;
	logic [7:0]  payload_byte;
	logic [14:0] payload_len;
	logic [31:0] req_len;
	logic        msg_first;
	logic        msg_last;

	sql_wire_message_capture dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.func        (func),
		.conn_slot   (conn_slot),
		.data_byte   (data_byte),
		.call_size   (call_size),
		.call_first  (call_first),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_slot    (out_slot),
		.msg_tag     (msg_tag),
		.payload_byte(payload_byte),
		.payload_len (payload_len),
		.req_len     (req_len),
		.msg_first   (msg_first),
		.msg_last    (msg_last)
	);

	always #5 clk = ~clk;

	// Slot 5 is set up as a plaintext v3 connection and sends one short query;
	// slot 255 then opens an endless call carrying an SSL request.
	wire_item_t directed_rows [DIR_ROWS] = '{
		'{1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, CHK_NONE, '0},
		'{1'b0, 8'd5, 8'h00, 32'd8, 1'b1, CHK_NONE, '0},
		'{1'b0, 8'd5, 8'h00, 32'd8, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'd5, 8'h00, 32'd8, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'd5, 8'h08, 32'd8, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'd5, 8'h00, 32'd8, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'd5, 8'h03, 32'd8, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'd5, 8'h00, 32'd8, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'd5, 8'h00, 32'd8, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'd5, TAG_QUERY, 32'd7, 1'b1, CHK_NONE, '0},
		'{1'b0, 8'd5, 8'h00, 32'd7, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'd5, 8'h00, 32'd7, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'd5, 8'h00, 32'd7, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'd5, 8'h06, 32'd7, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'd5, 8'h41, 32'd7, 1'b0, CHK_GIVEN,
			'{8'd5, TAG_QUERY, 8'h41, 15'd2, 32'd7, 1'b1, 1'b0}},
		'{1'b0, 8'd5, 8'h42, 32'd7, 1'b0, CHK_GIVEN,
			'{8'd5, TAG_QUERY, 8'h42, 15'd2, 32'd7, 1'b0, 1'b1}},
		'{1'b0, 8'd5, 8'hFF, 32'd0, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'hFF, 8'h00, 32'hFFFF_FFFF, 1'b1, CHK_NONE, '0},
		'{1'b0, 8'hFF, 8'h00, 32'hFFFF_FFFF, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'hFF, 8'h00, 32'hFFFF_FFFF, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'hFF, 8'h08, 32'hFFFF_FFFF, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'hFF, 8'h04, 32'hFFFF_FFFF, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'hFF, 8'hD2, 32'hFFFF_FFFF, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'hFF, 8'h16, 32'hFFFF_FFFF, 1'b0, CHK_NONE, '0},
		'{1'b0, 8'hFF, 8'h2F, 32'hFFFF_FFFF, 1'b0, CHK_NONE, '0}
	};

	wire_item_t  stim_q [$];
	capture_t    pending_bytes [$];
	cls_t        plan_cls [CONN_SLOTS_DEF];
	logic [7:0]  slot_pool [6];

	cls_t        slot_cls [CONN_SLOTS_DEF];
	phase_t      p_phase;
	logic [31:0] p_pos;
	logic [31:0] p_rem;
	logic [31:0] len_acc;
	logic [31:0] msg_left;
	logic [31:0] m_req;
	logic [7:0]  cur_tag;
	logic [7:0]  c_slot;
	int unsigned hdr_cnt;
	int unsigned cap_cnt;
	int unsigned msg_cnt;
	bit          cap_on;

	int  err_cnt;
	int  sent_cnt;
	int  close_cnt;
	int  got_cnt;
	int  msgs_seen;
	bit  quiet;
	bit  held_off;

	task automatic flag_mismatch(input string what);
		err_cnt++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	function automatic bit captures_tag(input logic [7:0] t);
		return t == TAG_QUERY || t == TAG_PARSE || t == TAG_BIND ||
			t == TAG_EXECUTE || t == TAG_CLOSE || t == TAG_TERMINATE;
	endfunction

	function automatic logic [31:0] capped(input logic [31:0] raw);
		logic [31:0] n;
		n = raw - 32'd4;
		return (n > MAX_CAPTURE_DEF) ? MAX_CAPTURE_DEF : n;
	endfunction

	task automatic frame_and_capture(input wire_item_t it, output bit got, output capture_t r);
		logic [31:0] left;
		logic [31:0] cap;
		cls_t        c;
		got = 1'b0;
		r = '0;
		if (it.func) begin
			slot_cls[it.slot] = CLS_NONE;
			return;
		end
		if (it.first) begin
			c = slot_cls[it.slot];
			c_slot = it.slot;
			p_rem = it.size;
			p_pos = '0;
			msg_cnt = 0;
			hdr_cnt = 0;
			cap_on = 1'b0;
			if (c == CLS_NONE) begin
				p_phase = (it.size < 8) ? PH_SKIP : PH_CLASSIFY;
			end else if (c == CLS_OTHER) begin
				p_phase = PH_SKIP;
			end else begin
				p_phase = PH_HEADER;
			end
		end
		if (p_phase == PH_IDLE || p_rem == 0) begin
			p_phase = PH_IDLE;
			return;
		end
		left = p_rem;
		case (p_phase)
			PH_CLASSIFY: begin
				if (p_pos >= 4) begin
					len_acc = {len_acc[23:0], it.data};
					if (p_pos == 7) begin
						if (len_acc[31:16] == PROTO_V3_MAJOR) begin
							c = CLS_V3;
						end else if (len_acc == SSL_REQUEST_CODE) begin
							c = CLS_SSL;
						end else if (len_acc == GSS_REQUEST_CODE) begin
							c = CLS_GSS;
						end else begin
							c = CLS_OTHER;
						end
						slot_cls[c_slot] = c;
						p_phase = PH_SKIP;
					end
				end
			end
			PH_HEADER: begin
				if (hdr_cnt == 0) begin
					if (msg_cnt >= MAX_MESSAGES_DEF || left < 5) begin
						p_phase = PH_SKIP;
					end else begin
						cur_tag = it.data;
						m_req = left;
						len_acc = '0;
						hdr_cnt = 1;
					end
				end else begin
					len_acc = {len_acc[23:0], it.data};
					hdr_cnt++;
					if (hdr_cnt == 5) begin
						hdr_cnt = 0;
						if (len_acc < 5 || capped(len_acc) > left - 32'd1) begin
							p_phase = PH_SKIP;
						end else begin
							msg_left = len_acc - 32'd4;
							cap_cnt = 0;
							cap_on = captures_tag(cur_tag);
							msg_cnt++;
							p_phase = PH_PAYLOAD;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				cap = capped(len_acc);
				if (cap_on && cap_cnt < cap) begin
					r.slot = c_slot;
					r.tag = cur_tag;
					r.pbyte = it.data;
					r.plen = cap[14:0];
					r.rlen = m_req;
					r.first = (cap_cnt == 0);
					r.last = (cap_cnt + 1 == cap);
					cap_cnt++;
					got = 1'b1;
				end
				msg_left--;
				if (msg_left == 0) begin
					p_phase = PH_HEADER;
					hdr_cnt = 0;
					cap_on = 1'b0;
				end
			end
			default: ;
		endcase
		p_rem--;
		p_pos++;
		if (p_rem == 0) begin
			p_phase = PH_IDLE;
		end
	endtask

	task automatic push_item(input logic f, input logic [7:0] s, input logic [7:0] d,
			input logic [31:0] sz, input logic fst);
		wire_item_t it;
		it = '0;
		it.func = f;
		it.slot = s;
		it.data = d;
		it.size = sz;
		it.first = fst;
		it.chk = CHK_MODEL;
		stim_q.push_back(it);
	endtask

	function automatic logic [7:0] pick_tag();
		logic [7:0] wanted [6] = '{TAG_QUERY, TAG_PARSE, TAG_BIND, TAG_EXECUTE,
			TAG_CLOSE, TAG_TERMINATE};
		if ($urandom_range(0, 4) == 0) begin
			return 8'($urandom);
		end
		return wanted[$urandom_range(0, 5)];
	endfunction

	task automatic gen_startup(input logic [7:0] s);
		int          sel;
		int          sz;
		int          k;
		logic [31:0] code;
		logic [7:0]  b;
		sel = $urandom_range(0, 99);
		sz = ($urandom_range(0, 3) == 0) ? 8 + $urandom_range(1, 4) : 8;
		code = $urandom;
		if (sel < 45) begin
			code[31:16] = PROTO_V3_MAJOR;
			plan_cls[s] = CLS_V3;
		end else if (sel < 60) begin
			code = SSL_REQUEST_CODE;
			plan_cls[s] = CLS_SSL;
		end else if (sel < 75) begin
			code = GSS_REQUEST_CODE;
			plan_cls[s] = CLS_GSS;
		end else if (sel < 88) begin
			plan_cls[s] = CLS_OTHER;
		end else begin
			sz = $urandom_range(1, 7);
		end
		for (k = 0; k < sz; k++) begin
			b = (k >= 4 && k < 8) ? code[8 * (7 - k) +: 8] : 8'($urandom);
			push_item(1'b0, s, b, sz, k == 0);
		end
	endtask

	task automatic gen_messages(input logic [7:0] s, input int n_msg, input int max_pay,
			input bit allow_brk);
		logic [7:0]  bytes_q [$];
		logic [31:0] len;
		logic [31:0] size;
		logic [7:0]  other;
		brk_t        brk;
		int          plen;
		int          k;
		int          j;
		int          close_at;
		brk = BRK_NONE;
		if (allow_brk && $urandom_range(0, 99) < 30) begin
			brk = brk_t'($urandom_range(1, 7));
		end
		for (k = 0; k < n_msg; k++) begin
			plen = $urandom_range(1, max_pay);
			len = plen + 4;
			if (k == n_msg - 1) begin
				case (brk)
					BRK_LEN:  len = $urandom_range(0, 4);
					BRK_LONG: len = len + $urandom_range(1, 40);
					BRK_HUGE: begin
						len = $urandom;
						if (len < 32'h4005) begin
							len = len + 32'h4005;
						end
						plen = $urandom_range(3, 8);
					end
					default: ;
				endcase
			end
			bytes_q.push_back(pick_tag());
			for (j = 3; j >= 0; j--) begin
				bytes_q.push_back(len[8 * j +: 8]);
			end
			for (j = 0; j < plen; j++) begin
				bytes_q.push_back(8'($urandom));
			end
		end
		size = bytes_q.size();
		case (brk)
			BRK_JUNK: begin
				for (j = $urandom_range(1, 4); j > 0; j--) begin
					bytes_q.push_back(8'($urandom));
				end
				size = bytes_q.size();
			end
			BRK_CUT:  size = $urandom_range(1, bytes_q.size() - 1);
			BRK_OPEN: begin
				if ($urandom_range(0, 1) == 0) begin
					size = $urandom;
				end
				j = $urandom_range(2, bytes_q.size() - 1);
				while (bytes_q.size() > j) begin
					void'(bytes_q.pop_back());
				end
			end
			BRK_HUGE: size = $urandom | 32'h8000_0000;
			default: ;
		endcase
		close_at = (brk == BRK_CLOSE) ? $urandom_range(1, bytes_q.size() - 1) : -1;
		for (k = 0; k < bytes_q.size(); k++) begin
			if (k == close_at) begin
				other = ($urandom_range(0, 1) == 0) ? s : 8'($urandom);
				push_item(1'b1, other, 8'($urandom), $urandom, 1'($urandom_range(0, 1)));
				plan_cls[other] = CLS_NONE;
			end
			push_item(1'b0, s, bytes_q[k], size, k == 0);
		end
	endtask

	task automatic gen_noise();
		int n;
		for (n = $urandom_range(1, 3); n > 0; n--) begin
			push_item($urandom_range(0, 4) == 0, 8'($urandom), 8'($urandom),
				($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom),
				$urandom_range(0, 3) == 0);
		end
	endtask

	task automatic gen_random();
		logic [7:0] s;
		int         r;
		bit         max_done;
		int         target;
		max_done = 1'b0;
		target = stim_q.size() + RAND_ITEMS;
		slot_pool[0] = 8'd0;
		slot_pool[1] = 8'hFF;
		for (r = 2; r < 6; r++) begin
			slot_pool[r] = 8'($urandom);
		end
		while (stim_q.size() < target) begin
			s = slot_pool[$urandom_range(0, 5)];
			r = $urandom_range(0, 99);
			if (r < 6 || plan_cls[s] == CLS_OTHER) begin
				push_item(1'b1, s, 8'($urandom), $urandom, 1'($urandom_range(0, 1)));
				plan_cls[s] = CLS_NONE;
			end else if (r < 14) begin
				gen_noise();
			end else if (plan_cls[s] == CLS_NONE) begin
				gen_startup(s);
			end else if (!max_done && stim_q.size() > 400) begin
				gen_messages(s, MAX_MESSAGES_DEF + 2, 1, 1'b0);
				max_done = 1'b1;
			end else begin
				gen_messages(s, $urandom_range(1, 4),
					($urandom_range(0, 3) == 0) ? 24 : 8, 1'b1);
			end
		end
	endtask

	task automatic note_transfer(input wire_item_t it);
		bit       got;
		capture_t r;
		sent_cnt++;
		if (it.func) begin
			close_cnt++;
		end
		frame_and_capture(it, got, r);
		case (it.chk)
			CHK_GIVEN: pending_bytes.push_back(it.want);
			CHK_MODEL: begin
				if (got) begin
					pending_bytes.push_back(r);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		capture_t e;
		if (arst_n && result_valid && !result_stall) begin
			got_cnt++;
			if (msg_first) begin
				msgs_seen++;
			end
			if (pending_bytes.size() == 0) begin
				flag_mismatch("result transfer with nothing expected");
			end else begin
				e = pending_bytes.pop_front();
				if (out_slot !== e.slot)
					flag_mismatch($sformatf("out_slot %0h, want %0h", out_slot, e.slot));
				if (msg_tag !== e.tag)
					flag_mismatch($sformatf("msg_tag %0h, want %0h", msg_tag, e.tag));
				if (payload_byte !== e.pbyte)
					flag_mismatch($sformatf("payload_byte %0h, want %0h",
						payload_byte, e.pbyte));
				if (payload_len !== e.plen)
					flag_mismatch($sformatf("payload_len %0d, want %0d",
						payload_len, e.plen));
				if (req_len !== e.rlen)
					flag_mismatch($sformatf("req_len %0h, want %0h", req_len, e.rlen));
				if (msg_first !== e.first)
					flag_mismatch($sformatf("msg_first %0b, want %0b", msg_first, e.first));
				if (msg_last !== e.last)
					flag_mismatch($sformatf("msg_last %0b, want %0b", msg_last, e.last));
			end
		end
	end

	initial begin
		int k;
		result_stall = 1'b0;
		@(negedge clk);
		wait (arst_n);
		forever begin
			if (!held_off && sent_cnt >= HOLD_AFTER) begin
				held_off = 1'b1;
				result_stall <= 1'b1;
				for (k = 0; k < HOLD_CYCLES; k++) begin
					@(negedge clk);
				end
			end else if (quiet) begin
				result_stall <= 1'b0;
				@(negedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end
	end

	initial begin
		int i;
		int burst_left;
		bit gappy;
		arst_n = 1'b0;
		item_valid = 1'b0;
		func = 1'b0;
		conn_slot = '0;
		data_byte = '0;
		call_size = '0;
		call_first = 1'b0;
		burst_left = 0;
		gappy = 1'b0;
		foreach (slot_cls[k]) begin
			slot_cls[k] = CLS_NONE;
			plan_cls[k] = CLS_NONE;
		end
		p_phase = PH_IDLE;
		p_pos = '0;
		p_rem = '0;
		len_acc = '0;
		msg_left = '0;
		m_req = '0;
		cur_tag = '0;
		c_slot = '0;
		hdr_cnt = 0;
		cap_cnt = 0;
		msg_cnt = 0;
		cap_on = 1'b0;
		foreach (directed_rows[k]) begin
			stim_q.push_back(directed_rows[k]);
		end
		plan_cls[5] = CLS_V3;
		plan_cls[255] = CLS_SSL;
		gen_random();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (i = 0; i < stim_q.size(); i++) begin
			quiet = (i >= stim_q.size() - QUIET_ITEMS);
			if (burst_left == 0) begin
				gappy = 1'($urandom_range(0, 1));
				burst_left = $urandom_range(10, 60);
			end
			burst_left--;
			if (gappy && !quiet && $urandom_range(0, 3) == 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			item_valid <= 1'b1;
			func <= stim_q[i].func;
			conn_slot <= stim_q[i].slot;
			data_byte <= stim_q[i].data;
			call_size <= stim_q[i].size;
			call_first <= stim_q[i].first;
			@(posedge clk);
			while (item_stall) @(posedge clk);
			note_transfer(stim_q[i]);
			@(negedge clk);
		end
		item_valid <= 1'b0;

		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d transfers (%0d close events) over startup, framed and broken calls.",
			sent_cnt, close_cnt);
		$display("Checked %0d captured bytes from %0d messages; %0d mismatches.",
			got_cnt, msgs_seen, err_cnt);
		if (err_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("Timed out with %0d bytes still expected.", pending_bytes.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
